/* sv/cfss_pkg.sv */
package cfss_pkg;

    localparam int FRAME_BYTES   = 20;
    localparam int DIGIT_BYTES   = 18;
    localparam int CATHODE_BYTES = 6;
    localparam int POS_W         = 5;
    localparam int VALUE_W       = 7;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0]   LAST_POS     = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0]   YEAR_ZERO_POS = POS_W'(DIGIT_BYTES);
    localparam logic [VALUE_W-1:0] VALUE_MAX    = 7'd99;
    localparam logic [3:0]         CONST_ZERO   = 4'd0;
    localparam logic [3:0]         CONST_TWO    = 4'd2;

    typedef logic [3:0] digit_t;
    typedef digit_t [DIGIT_BYTES-1:0] digit_frame_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        digit_t tens;
        digit_t units;
    } digit_pair_t;

    function automatic digit_pair_t split_value(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] sat;
        logic [14:0]        prod;
        logic [VALUE_W-1:0] tens_times_ten;
        logic [VALUE_W-1:0] units_wide;
        digit_pair_t        pair;
        sat            = (raw > VALUE_MAX) ? VALUE_MAX : raw;
        prod           = 15'({8'd0, sat} * 15'd205);
        pair.tens      = prod[14:11];
        tens_times_ten = VALUE_W'({3'd0, pair.tens} * 7'd10);
        units_wide     = sat - tens_times_ten;
        pair.units     = units_wide[3:0];
        return pair;
    endfunction

    function automatic logic [7:0] cathode_code(input digit_t d);
        logic [7:0] code;
        case (d)
            4'd0:    code = 8'h3f;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h4f;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6d;
            4'd6:    code = 8'h7d;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7f;
            4'd9:    code = 8'h6f;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] anode_code(input digit_t d);
        logic [7:0] code;
        case (d)
            4'd0:    code = 8'hc0;
            4'd1:    code = 8'hf9;
            4'd2:    code = 8'ha4;
            4'd3:    code = 8'hb0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hf8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hff;
        endcase
        return code;
    endfunction

endpackage

/* sv/clock_frame_seven_segment_serializer_core.sv */
// Channel  Handshake                  Payload
// frame    frame_valid, frame_ready   seconds ... year_in_century, one request per frame
// byte     byte_valid, byte_ready     segment_byte, frame_end, twenty per frame
//
// A frame is accepted whenever the two-entry frame queue has room and is split
// into digits in the same cycle. The sender emits one byte per cycle while the
// byte side does not stall and a frame waits in the queue.
// Reset empties the queue and idles the sender; no clearing pass is needed.
// A stall on the byte side holds the current byte and fills the queue, after
// which frame_ready drops until a frame finishes.
module clock_frame_seven_segment_serializer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       frame_valid,
    output logic       frame_ready,
    input  logic [5:0] seconds,
    input  logic [5:0] minutes,
    input  logic [4:0] hours,
    input  logic [6:0] humidity_pct,
    input  logic [6:0] temperature_deg,
    input  logic [2:0] weekday,
    input  logic [4:0] day_of_month,
    input  logic [3:0] month_number,
    input  logic [6:0] year_in_century,
    output logic       byte_valid,
    input  logic       byte_ready,
    output logic [7:0] segment_byte,
    output logic       frame_end
);
    import cfss_pkg::*;

    digit_frame_t  split_digits;
    digit_frame_t  head_digits;
    queue_status_t status;
    logic          push;
    logic          pop;

    assign frame_ready = !status.full;
    assign push        = frame_valid && !status.full;

    cfss_front u_front (
        .seconds         (seconds),
        .minutes         (minutes),
        .hours           (hours),
        .humidity_pct    (humidity_pct),
        .temperature_deg (temperature_deg),
        .weekday         (weekday),
        .day_of_month    (day_of_month),
        .month_number    (month_number),
        .year_in_century (year_in_century),
        .digits          (split_digits)
    );

    cfss_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_digits (split_digits),
        .pop         (pop),
        .head_digits (head_digits),
        .status      (status)
    );

    cfss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_digits  (head_digits),
        .status       (status),
        .pop          (pop),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .segment_byte (segment_byte),
        .frame_end    (frame_end)
    );

endmodule

/* sv/cfss_front.sv */
module cfss_front (
    input  logic [5:0]            seconds,
    input  logic [5:0]            minutes,
    input  logic [4:0]            hours,
    input  logic [6:0]            humidity_pct,
    input  logic [6:0]            temperature_deg,
    input  logic [2:0]            weekday,
    input  logic [4:0]            day_of_month,
    input  logic [3:0]            month_number,
    input  logic [6:0]            year_in_century,
    output cfss_pkg::digit_frame_t digits
);
    import cfss_pkg::*;

    digit_pair_t sec_pair;
    digit_pair_t min_pair;
    digit_pair_t hour_pair;
    digit_pair_t hum_pair;
    digit_pair_t temp_pair;
    digit_pair_t wday_pair;
    digit_pair_t day_pair;
    digit_pair_t month_pair;
    digit_pair_t year_pair;

    always_comb
    begin
        sec_pair   = split_value({1'b0, seconds});
        min_pair   = split_value({1'b0, minutes});
        hour_pair  = split_value({2'b0, hours});
        hum_pair   = split_value(humidity_pct);
        temp_pair  = split_value(temperature_deg);
        wday_pair  = split_value({4'b0, weekday});
        day_pair   = split_value({2'b0, day_of_month});
        month_pair = split_value({3'b0, month_number});
        year_pair  = split_value(year_in_century);

        digits[0]  = sec_pair.units;
        digits[1]  = sec_pair.tens;
        digits[2]  = min_pair.units;
        digits[3]  = min_pair.tens;
        digits[4]  = hour_pair.units;
        digits[5]  = hour_pair.tens;
        digits[6]  = hum_pair.units;
        digits[7]  = hum_pair.tens;
        digits[8]  = temp_pair.units;
        digits[9]  = temp_pair.tens;
        digits[10] = wday_pair.units;
        digits[11] = wday_pair.tens;
        digits[12] = day_pair.units;
        digits[13] = day_pair.tens;
        digits[14] = month_pair.units;
        digits[15] = month_pair.tens;
        digits[16] = year_pair.units;
        digits[17] = year_pair.tens;
    end

endmodule

/* sv/cfss_queue.sv */
module cfss_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cfss_pkg::digit_frame_t push_digits,
    input  logic                   pop,
    output cfss_pkg::digit_frame_t head_digits,
    output cfss_pkg::queue_status_t status
);
    import cfss_pkg::*;

    digit_frame_t entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    always_comb
    begin
        status.empty = (count_reg == '0);
        status.full  = (count_reg == CNT_FULL);
        head_digits  = entry_reg[rd_ptr_reg];
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_digits;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !status.full || pop)
        else $error("Frame written into a full queue.");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !status.empty)
        else $error("Frame taken from an empty queue.");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("Queue occupancy beyond its depth.");

endmodule

/* sv/cfss_back.sv */
module cfss_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfss_pkg::digit_frame_t  head_digits,
    input  cfss_pkg::queue_status_t status,
    output logic                    pop,
    output logic                    byte_valid,
    input  logic                    byte_ready,
    output logic [7:0]              segment_byte,
    output logic                    frame_end
);
    import cfss_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             end_reg;
    logic             end_next;
    logic             advance;
    logic             emit;
    logic             at_last;
    digit_t           digit;

    always_comb
    begin
        advance = !out_valid_reg || byte_ready;
        emit    = !status.empty && advance;
        at_last = (pos_reg == LAST_POS);
        pop     = emit && at_last;

        if (pos_reg < YEAR_ZERO_POS)
        begin
            digit = head_digits[pos_reg];
        end
        else if (pos_reg == YEAR_ZERO_POS)
        begin
            digit = CONST_ZERO;
        end
        else
        begin
            digit = CONST_TWO;
        end

        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        end_next       = end_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            byte_next      = (pos_reg < POS_W'(CATHODE_BYTES)) ? cathode_code(digit)
                                                               : anode_code(digit);
            end_next       = at_last;
            pos_next       = at_last ? '0 : pos_reg + 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

    assign byte_valid   = out_valid_reg;
    assign segment_byte = byte_reg;
    assign frame_end    = end_reg;

    assert property (@(posedge clk) disable iff (!rst_n) emit |=> end_reg == (pos_reg == '0))
        else $error("Frame end flag out of step with the byte position.");
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= LAST_POS)
        else $error("Byte position past the end of the frame.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != '0) |-> !status.empty)
        else $error("Frame left the queue before all of its bytes were sent.");

endmodule

/* dv/segment_stream_checker.sv */
`timescale 1ns / 1ps

module segment_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       frame_valid,
    input  logic       frame_ready,
    input  logic [5:0] seconds,
    input  logic [5:0] minutes,
    input  logic [4:0] hours,
    input  logic [6:0] humidity_pct,
    input  logic [6:0] temperature_deg,
    input  logic [2:0] weekday,
    input  logic [4:0] day_of_month,
    input  logic [3:0] month_number,
    input  logic [6:0] year_in_century,
    input  logic       byte_valid,
    input  logic       byte_ready,
    input  logic [7:0] segment_byte,
    input  logic       frame_end,
    output int         mismatch_count,
    output int         pending_bytes,
    output int         frames_seen,
    output int         bytes_seen
);

    typedef enum bit {
        COMMON_CATHODE,
        COMMON_ANODE
    } digit_drive_t;

    typedef struct packed {
        logic [7:0] pattern;
        logic       last;
    } segment_t;

    localparam int REPORT_LIMIT    = 10;
    localparam int DISPLAY_MAX     = 99;
    localparam int YEAR_PREFIX_LOW = 0;
    localparam int YEAR_PREFIX_HI  = 2;

    // Digit 0 sits in the lowest byte of each table.
    localparam logic [79:0] CATHODE_PATTERNS = {
        8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
    };
    localparam logic [79:0] ANODE_PATTERNS = {
        8'h90, 8'h80, 8'hf8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
    };

    segment_t expected_segments[$];

    initial
    begin
        mismatch_count = 0;
        pending_bytes  = 0;
        frames_seen    = 0;
        bytes_seen     = 0;
    end

    function automatic logic [7:0] digit_pattern(input int digit, input digit_drive_t drive);
        if (drive == COMMON_CATHODE)
        begin
            return CATHODE_PATTERNS[digit*8 +: 8];
        end
        return ANODE_PATTERNS[digit*8 +: 8];
    endfunction

    function automatic void push_segment(input logic [7:0] pattern, input logic last);
        segment_t entry;
        entry.pattern = pattern;
        entry.last    = last;
        expected_segments.push_back(entry);
    endfunction

    // Values above the two-digit range show as 99; the units digit goes out first.
    function automatic void push_value(input int raw, input digit_drive_t drive);
        int clipped;
        clipped = (raw > DISPLAY_MAX) ? DISPLAY_MAX : raw;
        push_segment(digit_pattern(clipped % 10, drive), 1'b0);
        push_segment(digit_pattern(clipped / 10, drive), 1'b0);
    endfunction

    function automatic void predict_frame();
        push_value(int'(seconds), COMMON_CATHODE);
        push_value(int'(minutes), COMMON_CATHODE);
        push_value(int'(hours), COMMON_CATHODE);
        push_value(int'(humidity_pct), COMMON_ANODE);
        push_value(int'(temperature_deg), COMMON_ANODE);
        push_value(int'(weekday), COMMON_ANODE);
        push_value(int'(day_of_month), COMMON_ANODE);
        push_value(int'(month_number), COMMON_ANODE);
        push_value(int'(year_in_century), COMMON_ANODE);
        push_segment(digit_pattern(YEAR_PREFIX_LOW, COMMON_ANODE), 1'b0);
        push_segment(digit_pattern(YEAR_PREFIX_HI, COMMON_ANODE), 1'b1);
    endfunction

    function automatic void note_mismatch(input string what, input segment_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected pattern %02h end %0b, got pattern %02h end %0b",
                     $time, what, want.pattern, want.last, segment_byte, frame_end);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        segment_t head;
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                bytes_seen++;
                if (expected_segments.size() == 0)
                begin
                    head = '0;
                    note_mismatch("segment byte with no frame pending", head);
                end
                else
                begin
                    head = expected_segments.pop_front();
                    if (segment_byte !== head.pattern || frame_end !== head.last)
                    begin
                        note_mismatch("segment byte mismatch", head);
                    end
                end
            end
            if (frame_valid && frame_ready)
            begin
                frames_seen++;
                predict_frame();
            end
            pending_bytes = expected_segments.size();
        end
    end

endmodule

/* dv/clock_frame_seven_segment_serializer_core_tb.sv */
`timescale 1ns / 1ps

module clock_frame_seven_segment_serializer_core_tb;

    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_FRAMES   = 480;
    localparam int IDLE_PERCENT    = 17;
    localparam int STEADY_FIRST    = 160;
    localparam int STEADY_LAST     = 260;
    localparam int HOLD_OFF_AT     = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_AT        = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 400000;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       frame_valid     = 1'b0;
    logic       frame_ready;
    logic [5:0] seconds         = '0;
    logic [5:0] minutes         = '0;
    logic [4:0] hours           = '0;
    logic [6:0] humidity_pct    = '0;
    logic [6:0] temperature_deg = '0;
    logic [2:0] weekday         = '0;
    logic [4:0] day_of_month    = '0;
    logic [3:0] month_number    = '0;
    logic [6:0] year_in_century = '0;
    logic       byte_valid;
    logic       byte_ready      = 1'b0;
    logic [7:0] segment_byte;
    logic       frame_end;

    int  mismatch_count;
    int  pending_bytes;
    int  frames_seen;
    int  bytes_seen;
    int  cycle_count      = 0;
    int  directed_frames  = 0;
    bit  steady_flow      = 1'b0;
    bit  hold_off_request = 1'b0;

    clock_frame_seven_segment_serializer_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_valid     (frame_valid),
        .frame_ready     (frame_ready),
        .seconds         (seconds),
        .minutes         (minutes),
        .hours           (hours),
        .humidity_pct    (humidity_pct),
        .temperature_deg (temperature_deg),
        .weekday         (weekday),
        .day_of_month    (day_of_month),
        .month_number    (month_number),
        .year_in_century (year_in_century),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .segment_byte    (segment_byte),
        .frame_end       (frame_end)
    );

    segment_stream_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_valid     (frame_valid),
        .frame_ready     (frame_ready),
        .seconds         (seconds),
        .minutes         (minutes),
        .hours           (hours),
        .humidity_pct    (humidity_pct),
        .temperature_deg (temperature_deg),
        .weekday         (weekday),
        .day_of_month    (day_of_month),
        .month_number    (month_number),
        .year_in_century (year_in_century),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .segment_byte    (segment_byte),
        .frame_end       (frame_end),
        .mismatch_count  (mismatch_count),
        .pending_bytes   (pending_bytes),
        .frames_seen     (frames_seen),
        .bytes_seen      (bytes_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("clock_frame_seven_segment_serializer_core regression: fail");
                $finish;
            end
        end
    end

    // The byte side stalls at random, except in the steady stretch, and stalls throughout a hold-off.
    initial
    begin : byte_side
        int held;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                byte_ready <= 1'b0;
                held = 0;
                while (held < HOLD_OFF_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                byte_ready <= 1'b1;
            end
            else
            begin
                byte_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic send_frame(input int s, input int mi, input int h, input int hu,
                              input int te, input int wk, input int dy, input int mo,
                              input int yr);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid     <= 1'b1;
        seconds         <= 6'(s);
        minutes         <= 6'(mi);
        hours           <= 5'(h);
        humidity_pct    <= 7'(hu);
        temperature_deg <= 7'(te);
        weekday         <= 3'(wk);
        day_of_month    <= 5'(dy);
        month_number    <= 4'(mo);
        year_in_century <= 7'(yr);
        do
        begin
            @(posedge clk);
        end
        while (!frame_ready);
    endtask

    // Mostly calendar-legal values, with a share that spans the full port width.
    function automatic int pick_field(input int width, input int low, input int high);
        if ($urandom_range(9) < 7)
        begin
            return $urandom_range(high, low);
        end
        return $urandom_range((1 << width) - 1, 0);
    endfunction

    task automatic wait_for_drain();
        while (pending_bytes != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    initial
    begin : frame_side
        int d;
        int i;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_frame(59, 59, 23, 99, 99, 6, 31, 12, 99);
        send_frame(63, 63, 31, 127, 127, 7, 31, 15, 127);
        send_frame(10, 20, 10, 100, 101, 1, 10, 10, 100);
        send_frame(45, 63, 31, 99, 0, 7, 0, 15, 1);
        directed_frames = 5;
        for (d = 0; d < 10; d++)
        begin
            send_frame((d % 6) * 10 + d, (5 - d % 6) * 10 + (9 - d), (d % 3) * 10 + d,
                       d * 11, 99 - d * 11, d % 8, d * 3 + 1, d + 1, d * 11);
            directed_frames++;
        end

        for (i = 0; i < RANDOM_FRAMES; i++)
        begin
            steady_flow = (i >= STEADY_FIRST && i < STEADY_LAST);
            if (i == HOLD_OFF_AT)
            begin
                hold_off_request = 1'b1;
            end
            if (i == DRAIN_AT)
            begin
                frame_valid <= 1'b0;
                wait_for_drain();
            end
            send_frame(pick_field(6, 0, 59), pick_field(6, 0, 59), pick_field(5, 0, 23),
                       pick_field(7, 0, 99), pick_field(7, 0, 99), pick_field(3, 0, 6),
                       pick_field(5, 1, 31), pick_field(4, 1, 12), pick_field(7, 0, 99));
        end
        steady_flow = 1'b0;
        frame_valid <= 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d frames (%0d directed), checked %0d segment bytes.",
                 frames_seen, directed_frames, bytes_seen);
        $display("Covered saturation, out-of-range digits, a long byte stall and a full drain.");
        if (mismatch_count == 0)
        begin
            $display("clock_frame_seven_segment_serializer_core regression: pass");
        end
        else
        begin
            $display("clock_frame_seven_segment_serializer_core regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
sv/cfss_pkg.sv
sv/cfss_front.sv
sv/cfss_queue.sv
sv/cfss_back.sv
sv/clock_frame_seven_segment_serializer_core.sv
dv/segment_stream_checker.sv
dv/clock_frame_seven_segment_serializer_core_tb.sv
